@@ src/smx_pkg.sv @@
package smx_pkg;

  localparam int MAX_CLASSES = 16;
  localparam int IDX_W = $clog2(MAX_CLASSES);
  localparam int CNT_W = $clog2(MAX_CLASSES + 1);
  localparam int SCORE_W = 16;
  localparam int EXP_W = 17;
  localparam int SUM_W = EXP_W + IDX_W;
  localparam int PROB_W = 17;
  localparam int OUT_IDX_W = 4;
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic                      is_last;
  } smx_req_t;

  function automatic logic [16:0] pow2_frac(input logic [7:0] k);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] acc;
    x = (64'(k) * 64'd744261118) >> 8;
    term = 64'd1 << 30;
    acc = 64'd1 << 30;
    for (int i = 1; i <= 12; i++) begin
      term = ((term * x) >> 30) / 64'(i);
      acc = acc + term;
    end
    return 17'((acc + (64'd1 << 13)) >> 14);
  endfunction

  // 2^(k/256) in Q16 for k = 0..255, entry k at bits [k*EXP_W +: EXP_W]
  function automatic logic [256*EXP_W-1:0] build_pow2_lut();
    logic [256*EXP_W-1:0] lut;
    lut = '0;
    for (int k = 0; k < 256; k++) begin
      lut[k*EXP_W +: EXP_W] = pow2_frac(8'(k));
    end
    return lut;
  endfunction

  localparam logic [256*EXP_W-1:0] POW2_LUT = build_pow2_lut();

endpackage

@@ src/softmax_unit.sv @@
// Flow: a request passes through the queue; after the last one the core runs EXP_RD,
// EXP_MUL and EXP_WR per element for exp and sum, then for each result the shared
// bit-serial divider (load, 33 steps, present, hand over); output stalls hold a result.
// Throughput: one request per cycle while collecting; during the pass the queue fills
// after two requests and the input stalls until the last result is taken.
// Reset: synchronous, active high; clears queue, count, max, sum, overflow and out_valid.
module softmax_unit
  import smx_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [SCORE_W-1:0]   score,
  input  logic                        is_last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [PROB_W-1:0]           probability,
  output logic [OUT_IDX_W-1:0]        element_index,
  output logic                        is_last_res,
  output logic                        overflowed
);

  smx_req_t q_in;
  smx_req_t q_out;
  logic     q_valid;
  logic     q_take;

  assign q_in.score = score;
  assign q_in.is_last = is_last;

  smx_fifo u_fifo (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(q_in),
    .out_valid(q_valid), .out_take(q_take), .out_data(q_out)
  );

  smx_core u_core (
    .clk(clk), .rst(rst), .req_valid(q_valid), .req_take(q_take), .req(q_out),
    .valid(out_valid), .stall(out_stall), .probability(probability),
    .element_index(element_index), .is_last_res(is_last_res), .overflowed(overflowed)
  );

endmodule

@@ src/smx_fifo.sv @@
module smx_fifo
  import smx_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  smx_req_t in_data,
  output logic     out_valid,
  input  logic     out_take,
  output smx_req_t out_data
);

  smx_req_t  mem [2];
  logic      wp;
  logic      rp;
  logic [1:0] cnt;
  logic      push;
  logic      pop;

  assign in_stall = (cnt == 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign out_data = mem[rp];
  assign push = in_valid && !in_stall;
  assign pop = out_valid && out_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= in_data;
    end
  end

endmodule

@@ src/smx_core.sv @@
module smx_core
  import smx_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_take,
  input  smx_req_t             req,
  output logic                 valid,
  input  logic                 stall,
  output logic [PROB_W-1:0]    probability,
  output logic [OUT_IDX_W-1:0] element_index,
  output logic                 is_last_res,
  output logic                 overflowed
);

  typedef enum logic [2:0] {COLLECT, EXP_RD, EXP_MUL, EXP_WR, DIV_LD, DIV_RUN, EMIT} state_t;

  state_t state;
  logic signed [SCORE_W-1:0] scores [MAX_CLASSES];
  logic [EXP_W-1:0]          exps [MAX_CLASSES];
  logic [CNT_W-1:0]          count;
  logic signed [SCORE_W-1:0] running_max;
  logic [SUM_W-1:0]          exp_sum;
  logic                      ovf;
  logic [IDX_W-1:0]          idx;
  logic [16:0]               mag;
  logic [33:0]               prod;
  logic [EXP_W-1:0]          e_val;
  logic [SUM_W-1:0]          rem;
  logic [EXP_W+15:0]         quo;
  logic [5:0]                bit_n;
  logic [16:0]               diff;
  logic [17:0]               u;
  logic [9:0]                n;
  logic [7:0]                f;
  logic [SUM_W:0]            rem_sh;
  logic [7:0]                lut_k;
  logic [EXP_W-1:0]          frac_val;

  assign req_take = (state == COLLECT);
  assign diff = 17'(signed'({running_max[SCORE_W-1], running_max})
                - signed'({scores[idx][SCORE_W-1], scores[idx]}));
  assign u = prod[33:16];
  assign n = u[17:8];
  assign f = u[7:0];
  assign rem_sh = {rem, quo[EXP_W+15]};
  assign lut_k = 8'(9'd256 - {1'b0, f});
  assign frac_val = POW2_LUT[int'(lut_k) * EXP_W +: EXP_W];

  always_comb begin
    if (f == 8'd0) begin
      e_val = (n >= 10'd17) ? '0 : EXP_W'(17'h10000 >> n);
    end else if (n >= 10'd16) begin
      e_val = '0;
    end else begin
      e_val = EXP_W'(frac_val >> (n + 10'd1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= COLLECT;
      count <= '0;
      running_max <= 16'sh8000;
      ovf <= 1'b0;
      exp_sum <= '0;
      idx <= '0;
      valid <= 1'b0;
      bit_n <= '0;
    end else begin
      case (state)
        COLLECT: begin
          if (req_valid) begin
            if (count < CNT_W'(MAX_CLASSES)) begin
              count <= count + 1'b1;
              if (req.score > running_max) begin
                running_max <= req.score;
              end
            end else begin
              ovf <= 1'b1;
            end
            if (req.is_last) begin
              idx <= '0;
              exp_sum <= '0;
              state <= EXP_RD;
            end
          end
        end
        EXP_RD: begin
          mag <= diff;
          state <= EXP_MUL;
        end
        EXP_MUL: begin
          prod <= mag * LOG2E_Q16;
          state <= EXP_WR;
        end
        EXP_WR: begin
          exp_sum <= exp_sum + SUM_W'(e_val);
          if (CNT_W'(idx) + 1'b1 == count) begin
            idx <= '0;
            state <= DIV_LD;
          end else begin
            idx <= idx + 1'b1;
            state <= EXP_RD;
          end
        end
        DIV_LD: begin
          rem <= '0;
          quo <= {exps[idx], 16'd0};
          bit_n <= 6'(EXP_W + 16);
          state <= DIV_RUN;
        end
        DIV_RUN: begin
          if (rem_sh >= {1'b0, exp_sum}) begin
            rem <= SUM_W'(rem_sh - {1'b0, exp_sum});
            quo <= {quo[EXP_W+14:0], 1'b1};
          end else begin
            rem <= SUM_W'(rem_sh);
            quo <= {quo[EXP_W+14:0], 1'b0};
          end
          bit_n <= bit_n - 1'b1;
          if (bit_n == 6'd1) begin
            state <= EMIT;
          end
        end
        EMIT: begin
          if (!valid) begin
            valid <= 1'b1;
            probability <= (exp_sum == '0) ? '0 : quo[PROB_W-1:0];
            element_index <= OUT_IDX_W'(idx);
            is_last_res <= (CNT_W'(idx) + 1'b1 == count);
            overflowed <= ovf;
          end else if (!stall) begin
            valid <= 1'b0;
            if (is_last_res) begin
              count <= '0;
              running_max <= 16'sh8000;
              ovf <= 1'b0;
              exp_sum <= '0;
              state <= COLLECT;
            end else begin
              idx <= idx + 1'b1;
              state <= DIV_LD;
            end
          end
        end
        default: state <= COLLECT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == COLLECT && req_valid && count < CNT_W'(MAX_CLASSES)) begin
      scores[count[IDX_W-1:0]] <= req.score;
    end
    if (state == EXP_WR) begin
      exps[idx] <= e_val;
    end
  end

endmodule

@@ src/smx_checker.sv @@
module smx_checker
  import smx_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [PROB_W-1:0]    probability,
  input logic [OUT_IDX_W-1:0] element_index,
  input logic                 is_last_res
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(probability)
      && $stable(element_index) && $stable(is_last_res))
    else $error("stalled result changed");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> probability <= 17'd65536)
    else $error("probability out of range");

  a_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && is_last_res |=> !out_valid)
    else $error("valid right after last result");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid right after reset");

endmodule

bind softmax_unit smx_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .probability(probability), .element_index(element_index), .is_last_res(is_last_res)
);
